// ===== rtl/core/sliding_window_peak_counter_defines.svh =====
// assertion macros for the peak counter rtl
`ifndef SLIDING_WINDOW_PEAK_COUNTER_DEFINES_SVH
`define SLIDING_WINDOW_PEAK_COUNTER_DEFINES_SVH

// checked only while out of reset
`define SWPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SWPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/swpc_pkg.sv =====
// types, constants and helpers for the sliding window peak counter
package swpc_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int MAX_LENGTH = 65536;
    localparam int MIN_WINDOW = 3;
    localparam int PEAK_CAP   = 1022;

    localparam int RING_AW  = $clog2(MAX_WINDOW);
    localparam int CNT_W    = $clog2(MAX_LENGTH) + 1;
    localparam int SAMPLE_W = 32;
    localparam int WLEN_W   = 11;
    localparam int PEAK_W   = 10;
    localparam int START_W  = 17;
    localparam int BSTART_W = 16;

    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
    } t_ring_rd;

    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic               data;
    } t_ring_wr;

    // window length clamped to the supported range
    function automatic logic [WLEN_W-1:0] eff_len(input logic [WLEN_W-1:0] v);
        logic [WLEN_W-1:0] k;
        k = v;
        if (v < WLEN_W'(MIN_WINDOW)) begin
            k = WLEN_W'(MIN_WINDOW);
        end else if (v > WLEN_W'(MAX_WINDOW)) begin
            k = WLEN_W'(MAX_WINDOW);
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/swpc_ring.sv =====
// peak flag ring: 1-bit synchronous memory with same-edge write forwarding
module swpc_ring
    import swpc_pkg::*;
(
    input  logic     i_clk,
    input  t_ring_rd i_rd,
    input  t_ring_wr i_wr,
    output logic     o_flag
);

    logic mem [MAX_WINDOW];
    logic r_rd_data;
    logic r_hit;
    logic r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data  <= mem[i_rd.addr];
            // a write to the same entry on the read edge wins
            r_hit      <= i_wr.en && (i_wr.addr == i_rd.addr);
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_flag = r_hit ? r_fwd_data : r_rd_data;

endmodule

// ===== rtl/core/sliding_window_peak_counter.sv =====
// sliding window peak counter top level
// throughput: one item per cycle while the result output is not stalled; the ring read
// is launched on the accept edge and the count update runs when the item leaves s1
// reset: synchronous active low, clears control and sequence state; window
// length returns to 3; the flag ring is not cleared
`include "sliding_window_peak_counter_defines.svh"

module sliding_window_peak_counter
    import swpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WLEN_W-1:0] i_cfg_data,      // window_length
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [31:0]       i_s_axis_tdata,  // sample
    input  logic              i_s_axis_tlast,  // end_of_sequence
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,  // parts[9:0], window_start[26:10], zero pad
    output logic              o_m_axis_tuser   // too_short
);

    logic [WLEN_W-1:0]   r_wlen;
    logic [WLEN_W-1:0]   k_eff;
    logic [WLEN_W-1:0]   km1;

    logic [CNT_W-1:0]    r_fcnt;
    logic [CNT_W-1:0]    n_fcnt;

    logic                r_s1_valid;
    logic                r_s1_eos;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [CNT_W-1:0]    r_s1_e;

    logic [SAMPLE_W-1:0] r_prev;
    logic [SAMPLE_W-1:0] r_prev2;
    logic [PEAK_W-1:0]   r_run;
    logic [PEAK_W-1:0]   r_best;
    logic [BSTART_W-1:0] r_best_start;

    logic                r_out_valid;
    logic [PEAK_W-1:0]   r_out_parts;
    logic [START_W-1:0]  r_out_start;
    logic                r_out_short;

    logic                s_acc;
    logic                s1_go;
    logic                live;
    logic                has_rm;
    logic                has_add;
    logic                removed;
    logic                added;
    logic                ring_flag;
    logic [PEAK_W-1:0]   run_dec;
    logic [PEAK_W-1:0]   n_run;
    logic [CNT_W-1:0]    e1;
    logic [CNT_W-1:0]    k_cnt;
    logic                take_best;
    logic [PEAK_W-1:0]   n_best;
    logic [BSTART_W-1:0] n_best_start;
    logic [CNT_W-1:0]    cnt_final;
    logic                seq_short;
    t_ring_rd            ring_rd;
    t_ring_wr            ring_wr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WLEN_W'(MIN_WINDOW);
        end else if (i_cfg_valid) begin
            r_wlen <= i_cfg_data;
        end
    end

    assign k_eff = eff_len(r_wlen);
    assign km1   = k_eff - WLEN_W'(1);
    assign k_cnt = CNT_W'(k_eff);

    // handshake
    assign s1_go           = r_s1_valid && (!r_s1_eos || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_go;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // front count tracks the position of the next item to be accepted
    always_comb begin
        n_fcnt = r_fcnt;
        if (i_s_axis_tlast) begin
            n_fcnt = '0;
        end else if (r_fcnt < CNT_W'(MAX_LENGTH)) begin
            n_fcnt = r_fcnt + CNT_W'(1);
        end
    end

    // flag that leaves the window interior, fetched on the accept edge
    assign ring_rd.en   = s_acc;
    assign ring_rd.addr = r_fcnt[RING_AW-1:0] - km1[RING_AW-1:0];

    swpc_ring u_ring (
        .i_clk  (i_clk),
        .i_rd   (ring_rd),
        .i_wr   (ring_wr),
        .o_flag (ring_flag)
    );

    // update of the window count
    always_comb begin
        live      = r_s1_e < CNT_W'(MAX_LENGTH);
        has_rm    = live && (r_s1_e >= k_cnt);
        has_add   = live && (r_s1_e >= CNT_W'(2));
        removed   = has_rm && ring_flag;
        added     = has_add && (r_prev > r_prev2) && (r_prev > r_s1_sample);
        run_dec   = (removed && (r_run != '0)) ? r_run - PEAK_W'(1) : r_run;
        n_run     = (added && (run_dec < PEAK_W'(PEAK_CAP))) ? run_dec + PEAK_W'(1) : run_dec;
        e1        = r_s1_e + CNT_W'(1);
        // earliest best window: ties keep the older start
        take_best = live && (e1 >= k_cnt) && ((e1 == k_cnt) || (n_run > r_best));
        n_best       = take_best ? n_run : r_best;
        n_best_start = take_best ? BSTART_W'(e1 - k_cnt) : r_best_start;
        cnt_final = live ? e1 : r_s1_e;
        seq_short = cnt_final < k_cnt;
    end

    // flag of the previous position becomes known with this sample
    assign ring_wr.en   = s1_go && has_add;
    assign ring_wr.addr = r_s1_e[RING_AW-1:0] - RING_AW'(1);
    assign ring_wr.data = added;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt       <= '0;
            r_s1_valid   <= 1'b0;
            r_prev       <= '0;
            r_prev2      <= '0;
            r_run        <= '0;
            r_best       <= '0;
            r_best_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_acc) begin
                r_fcnt <= n_fcnt;
            end
            if (s_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                if (r_s1_eos) begin
                    r_prev       <= '0;
                    r_prev2      <= '0;
                    r_run        <= '0;
                    r_best       <= '0;
                    r_best_start <= '0;
                end else if (live) begin
                    r_prev2      <= r_prev;
                    r_prev       <= r_s1_sample;
                    r_run        <= n_run;
                    r_best       <= n_best;
                    r_best_start <= n_best_start;
                end
            end
            if (s1_go && r_s1_eos) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_sample <= i_s_axis_tdata;
            r_s1_eos    <= i_s_axis_tlast;
            r_s1_e      <= r_fcnt;
        end
        if (s1_go && r_s1_eos) begin
            r_out_short <= seq_short;
            r_out_parts <= seq_short ? PEAK_W'(1) : n_best + PEAK_W'(1);
            r_out_start <= seq_short ? START_W'(1) : START_W'(n_best_start) + START_W'(1);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_start, r_out_parts};
    assign o_m_axis_tuser  = r_out_short;

    `SWPC_ASSERT(a_fcnt_range, r_fcnt <= CNT_W'(MAX_LENGTH), "front count beyond max length")
    `SWPC_ASSERT(a_run_cap, r_run <= PEAK_W'(PEAK_CAP), "running peaks beyond cap")
    `SWPC_ASSERT(a_eos_clears, (s_acc && i_s_axis_tlast) |=> (r_fcnt == '0),
                 "count not cleared after end item")
    `SWPC_ASSERT(a_stall_hold,
                 (r_s1_valid && r_s1_eos && r_out_valid && !i_m_axis_tready)
                 |=> (r_s1_valid && r_s1_eos),
                 "end item lost while output stalled")
    `SWPC_ASSERT_ALWAYS(a_reset_idle,
                        !i_rst_n |=> (!o_m_axis_tvalid && !r_s1_valid),
                        "pipeline not empty after reset")

endmodule
